FILE: rtl/core/binary_lz78_compressor_core_defines.svh
// Assertion macros for the binary LZ78 compressor core.
// Used by the top level; expects clk and rst_n in scope.
`ifndef BINARY_LZ78_COMPRESSOR_CORE_DEFINES_SVH
`define BINARY_LZ78_COMPRESSOR_CORE_DEFINES_SVH

// Check that a condition holds at every clock edge out of reset.
`define BLZ_ASSERT_ALWAYS(lbl, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("blz assertion failed");

// Check that a consequent follows an antecedent in the same cycle.
`define BLZ_ASSERT_IMP(lbl, pre, con) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (con)) \
        else $error("blz assertion failed");

`endif

FILE: rtl/core/blz_pkg.sv
// Shared types and constants for the binary LZ78 compressor core.
// No dependencies.
package blz_pkg;

    localparam int BYTE_W = 8;
    localparam int CFG_W  = 5;
    localparam logic [CFG_W-1:0] CFG_RESET = 5'd9;

    typedef struct packed {
        logic [BYTE_W-1:0] data;
        logic              eos;
    } blz_item_t;

    typedef struct packed {
        logic clearing;
        logic idle;
    } blz_stat_t;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_LOOK,
        S_DECIDE,
        S_CODE,
        S_ITEM_END,
        S_PAD,
        S_FINISH
    } blz_state_t;

endpackage

FILE: rtl/core/blz_front.sv
// Input side: accepts requests and holds them in a two-entry queue.
// Depends on blz_pkg.
module blz_front (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic [7:0]            data_byte,
    input  logic                  end_of_stream,
    output logic                  item_valid,
    output blz_pkg::blz_item_t    item,
    input  logic                  item_pop
);

    blz_pkg::blz_item_t q_reg [2];
    logic               wr_ptr_reg, wr_ptr_next;
    logic               rd_ptr_reg, rd_ptr_next;
    logic [1:0]         cnt_reg, cnt_next;
    logic               push;
    logic               pop;

    assign in_stall   = (cnt_reg == 2'd2);
    assign push       = in_valid && !in_stall;
    assign item_valid = (cnt_reg != 2'd0);
    assign pop        = item_pop && item_valid;
    assign item       = q_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? !rd_ptr_reg : rd_ptr_reg;
        cnt_next    = cnt_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[wr_ptr_reg] <= '{data: data_byte, eos: end_of_stream};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

endmodule

FILE: rtl/core/blz_back.sv
// Back end: walks the trie one bit at a time, emits codes and packs bytes.
// Holds the trie memory and the output register. Depends on blz_pkg.
module blz_back #(
    parameter int MAX_INDEX_BITS = 16
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic [4:0]            eff_bits,
    input  logic                  item_valid,
    input  blz_pkg::blz_item_t    item,
    output logic                  item_pop,
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic [7:0]            out_byte,
    output logic                  last_of_run,
    output blz_pkg::blz_stat_t    stat
);

    localparam int NW = MAX_INDEX_BITS;
    localparam int AW = MAX_INDEX_BITS + 1;
    localparam int CW = $clog2(MAX_INDEX_BITS + 2);
    localparam int IW = (AW > 1) ? $clog2(AW) : 1;
    localparam int DEPTH = 2 << MAX_INDEX_BITS;

    logic [NW-1:0] mem [DEPTH];
    logic [NW-1:0] rd_data_reg;

    blz_pkg::blz_state_t state_reg, state_next;
    logic [AW-1:0] clr_addr_reg, clr_addr_next;
    logic [7:0]    dat_reg, dat_next;
    logic [2:0]    bit_cnt_reg, bit_cnt_next;
    logic          bits_done_reg, bits_done_next;
    logic          eos_reg, eos_next;
    logic          fin_reg, fin_next;
    logic [NW-1:0] cur_reg, cur_next;
    logic [NW-1:0] parent_reg, parent_next;
    logic          plast_reg, plast_next;
    logic          popen_reg, popen_next;
    logic [NW-1:0] nidx_reg, nidx_next;
    logic [6:0]    pshift_reg, pshift_next;
    logic [2:0]    pcnt_reg, pcnt_next;
    logic [AW-1:0] code_reg, code_next;
    logic [CW-1:0] ccnt_reg, ccnt_next;
    logic [7:0]    pend_reg, pend_next;
    logic          pend_valid_reg, pend_valid_next;
    logic [7:0]    obyte_reg, obyte_next;
    logic          olast_reg, olast_next;
    logic          ovalid_reg, ovalid_next;

    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    logic [NW-1:0] mem_wdata;
    logic [AW-1:0] look_addr;
    logic [AW-1:0] limit;
    logic          out_free;
    logic          deliver_req;
    logic [7:0]    deliver_byte;
    logic          deliver_ok;
    logic          code_bit;
    logic [7:0]    pad_byte;

    assign look_addr = {cur_reg, dat_reg[7]};
    assign limit     = (AW'(1) << eff_bits) - AW'(1);
    assign out_free  = !ovalid_reg || !out_stall;
    assign deliver_ok = !pend_valid_reg || out_free;
    assign code_bit  = code_reg[IW'(ccnt_reg - CW'(1))];
    assign pad_byte  = 8'({1'b0, pshift_reg} << (4'd8 - {1'b0, pcnt_reg}));

    assign out_valid   = ovalid_reg;
    assign out_byte    = obyte_reg;
    assign last_of_run = olast_reg;
    assign stat.clearing = (state_reg == blz_pkg::S_CLEAR);
    assign stat.idle     = (state_reg == blz_pkg::S_IDLE);

    always_comb
    begin
        state_next      = state_reg;
        clr_addr_next   = clr_addr_reg;
        dat_next        = dat_reg;
        bit_cnt_next    = bit_cnt_reg;
        bits_done_next  = bits_done_reg;
        eos_next        = eos_reg;
        fin_next        = fin_reg;
        cur_next        = cur_reg;
        parent_next     = parent_reg;
        plast_next      = plast_reg;
        popen_next      = popen_reg;
        nidx_next       = nidx_reg;
        pshift_next     = pshift_reg;
        pcnt_next       = pcnt_reg;
        code_next       = code_reg;
        ccnt_next       = ccnt_reg;
        pend_next       = pend_reg;
        pend_valid_next = pend_valid_reg;
        obyte_next      = obyte_reg;
        olast_next      = olast_reg;
        ovalid_next     = ovalid_reg && out_stall;
        item_pop        = 1'b0;
        mem_we          = 1'b0;
        mem_waddr       = look_addr;
        mem_wdata       = '0;
        deliver_req     = 1'b0;
        deliver_byte    = '0;

        case (state_reg)
            blz_pkg::S_CLEAR:
            begin
                mem_we        = 1'b1;
                mem_waddr     = clr_addr_reg;
                clr_addr_next = clr_addr_reg + AW'(1);
                if (&clr_addr_reg)
                begin
                    state_next = blz_pkg::S_IDLE;
                end
            end
            blz_pkg::S_IDLE:
            begin
                if (item_valid)
                begin
                    item_pop       = 1'b1;
                    dat_next       = item.data;
                    eos_next       = item.eos;
                    bit_cnt_next   = 3'd0;
                    bits_done_next = 1'b0;
                    fin_next       = 1'b0;
                    state_next     = blz_pkg::S_LOOK;
                end
            end
            blz_pkg::S_LOOK:
            begin
                state_next = blz_pkg::S_DECIDE;
            end
            blz_pkg::S_DECIDE:
            begin
                dat_next       = {dat_reg[6:0], 1'b0};
                bit_cnt_next   = bit_cnt_reg + 3'd1;
                bits_done_next = (bit_cnt_reg == 3'd7);
                if (rd_data_reg != '0)
                begin
                    parent_next = cur_reg;
                    cur_next    = rd_data_reg;
                    plast_next  = dat_reg[7];
                    popen_next  = 1'b1;
                    state_next  = (bit_cnt_reg == 3'd7) ? blz_pkg::S_ITEM_END
                                                        : blz_pkg::S_LOOK;
                end
                else
                begin
                    if ({1'b0, nidx_reg} < limit)
                    begin
                        nidx_next = nidx_reg + NW'(1);
                        mem_we    = 1'b1;
                        mem_wdata = nidx_reg + NW'(1);
                    end
                    code_next   = {cur_reg, dat_reg[7]};
                    ccnt_next   = CW'(eff_bits) + CW'(1);
                    cur_next    = '0;
                    parent_next = '0;
                    plast_next  = 1'b0;
                    popen_next  = 1'b0;
                    state_next  = blz_pkg::S_CODE;
                end
            end
            blz_pkg::S_CODE:
            begin
                if (pcnt_reg == 3'd7)
                begin
                    deliver_req  = 1'b1;
                    deliver_byte = {pshift_reg, code_bit};
                end
                if (pcnt_reg != 3'd7 || deliver_ok)
                begin
                    if (pcnt_reg == 3'd7)
                    begin
                        pshift_next = '0;
                        pcnt_next   = 3'd0;
                    end
                    else
                    begin
                        pshift_next = {pshift_reg[5:0], code_bit};
                        pcnt_next   = pcnt_reg + 3'd1;
                    end
                    ccnt_next = ccnt_reg - CW'(1);
                    if (ccnt_reg == CW'(1))
                    begin
                        if (fin_reg)
                        begin
                            state_next = blz_pkg::S_PAD;
                        end
                        else if (bits_done_reg)
                        begin
                            state_next = blz_pkg::S_ITEM_END;
                        end
                        else
                        begin
                            state_next = blz_pkg::S_LOOK;
                        end
                    end
                end
            end
            blz_pkg::S_ITEM_END:
            begin
                if (!eos_reg)
                begin
                    state_next = blz_pkg::S_FINISH;
                end
                else if (popen_reg)
                begin
                    fin_next   = 1'b1;
                    code_next  = {parent_reg, plast_reg};
                    ccnt_next  = CW'(eff_bits) + CW'(1);
                    state_next = blz_pkg::S_CODE;
                end
                else
                begin
                    state_next = blz_pkg::S_PAD;
                end
            end
            blz_pkg::S_PAD:
            begin
                if (pcnt_reg == 3'd0)
                begin
                    state_next = blz_pkg::S_FINISH;
                end
                else
                begin
                    deliver_req  = 1'b1;
                    deliver_byte = pad_byte;
                    if (deliver_ok)
                    begin
                        pshift_next = '0;
                        pcnt_next   = 3'd0;
                        state_next  = blz_pkg::S_FINISH;
                    end
                end
            end
            blz_pkg::S_FINISH:
            begin
                if (!pend_valid_reg || out_free)
                begin
                    if (pend_valid_reg)
                    begin
                        obyte_next      = pend_reg;
                        olast_next      = 1'b1;
                        ovalid_next     = 1'b1;
                        pend_valid_next = 1'b0;
                    end
                    if (eos_reg)
                    begin
                        nidx_next     = '0;
                        cur_next      = '0;
                        parent_next   = '0;
                        plast_next    = 1'b0;
                        popen_next    = 1'b0;
                        clr_addr_next = '0;
                        state_next    = blz_pkg::S_CLEAR;
                    end
                    else
                    begin
                        state_next = blz_pkg::S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = blz_pkg::S_IDLE;
            end
        endcase

        if (deliver_req && deliver_ok)
        begin
            if (pend_valid_reg)
            begin
                obyte_next  = pend_reg;
                olast_next  = 1'b0;
                ovalid_next = 1'b1;
            end
            pend_next       = deliver_byte;
            pend_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        rd_data_reg <= mem[look_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= blz_pkg::S_CLEAR;
            clr_addr_reg   <= '0;
            dat_reg        <= '0;
            bit_cnt_reg    <= '0;
            bits_done_reg  <= 1'b0;
            eos_reg        <= 1'b0;
            fin_reg        <= 1'b0;
            cur_reg        <= '0;
            parent_reg     <= '0;
            plast_reg      <= 1'b0;
            popen_reg      <= 1'b0;
            nidx_reg       <= '0;
            pshift_reg     <= '0;
            pcnt_reg       <= '0;
            code_reg       <= '0;
            ccnt_reg       <= '0;
            pend_reg       <= '0;
            pend_valid_reg <= 1'b0;
            obyte_reg      <= '0;
            olast_reg      <= 1'b0;
            ovalid_reg     <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            clr_addr_reg   <= clr_addr_next;
            dat_reg        <= dat_next;
            bit_cnt_reg    <= bit_cnt_next;
            bits_done_reg  <= bits_done_next;
            eos_reg        <= eos_next;
            fin_reg        <= fin_next;
            cur_reg        <= cur_next;
            parent_reg     <= parent_next;
            plast_reg      <= plast_next;
            popen_reg      <= popen_next;
            nidx_reg       <= nidx_next;
            pshift_reg     <= pshift_next;
            pcnt_reg       <= pcnt_next;
            code_reg       <= code_next;
            ccnt_reg       <= ccnt_next;
            pend_reg       <= pend_next;
            pend_valid_reg <= pend_valid_next;
            obyte_reg      <= obyte_next;
            olast_reg      <= olast_next;
            ovalid_reg     <= ovalid_next;
        end
    end

endmodule

FILE: rtl/core/binary_lz78_compressor_core.sv
// Top level of the binary LZ78 compressor: config register, front queue, back end.
// Depends on blz_pkg, blz_front, blz_back and the core defines header.
//
// Each input byte walks the trie one bit at a time, each bit taking a registered
// read of the trie memory and then a decision. Every phrase closed, the open
// phrase at end of stream included, is emitted as a code of effective
// index_bits + 1 bits, sent bit by bit. Each byte also passes the accept, end of
// byte and finish states, and a byte marked end_of_stream the pad state too; a
// stalled output adds its wait. After reset and after every byte marked
// end_of_stream all 2^(MAX_INDEX_BITS+1) entries of the trie memory are cleared
// one entry per cycle, during which requests queue up but are not processed.
// The user must write index_bits only while the block is idle; it is not enforced.
`include "binary_lz78_compressor_core_defines.svh"

module binary_lz78_compressor_core #(
    parameter int MAX_INDEX_BITS = 16
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_we,
    input  logic [4:0] cfg_wdata,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] data_byte,
    input  logic       end_of_stream,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [7:0] out_byte,
    output logic       last_of_run
);

    logic [4:0]         index_bits_reg, index_bits_next;
    logic [4:0]         eff_bits;
    logic               item_valid;
    blz_pkg::blz_item_t item;
    logic               item_pop;
    blz_pkg::blz_stat_t stat;

    assign index_bits_next = cfg_we ? cfg_wdata : index_bits_reg;

    always_comb
    begin
        if (index_bits_reg == 5'd0)
        begin
            eff_bits = 5'd1;
        end
        else if (index_bits_reg > 5'(MAX_INDEX_BITS))
        begin
            eff_bits = 5'(MAX_INDEX_BITS);
        end
        else
        begin
            eff_bits = index_bits_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            index_bits_reg <= blz_pkg::CFG_RESET;
        end
        else
        begin
            index_bits_reg <= index_bits_next;
        end
    end

    blz_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .data_byte    (data_byte),
        .end_of_stream(end_of_stream),
        .item_valid   (item_valid),
        .item         (item),
        .item_pop     (item_pop)
    );

    blz_back #(
        .MAX_INDEX_BITS(MAX_INDEX_BITS)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .eff_bits   (eff_bits),
        .item_valid (item_valid),
        .item       (item),
        .item_pop   (item_pop),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .out_byte   (out_byte),
        .last_of_run(last_of_run),
        .stat       (stat)
    );

    `BLZ_ASSERT_ALWAYS(a_eff_range, eff_bits != 5'd0 && eff_bits <= 5'(MAX_INDEX_BITS))
    `BLZ_ASSERT_IMP(a_clear_to_idle, $fell(stat.clearing), stat.idle)
    `BLZ_ASSERT_IMP(a_pop_only_idle, item_pop, stat.idle && item_valid)

endmodule

FILE: bench/tb.sv
// Self-checking bench for binary_lz78_compressor_core: queued byte requests, trie predictor.
// Depends on blz_pkg and the core RTL; compares each output byte against predicted codes.
module tb;

    localparam int MAX_W = 16;
    localparam int CLEAR_CYCLES = (2 << MAX_W) + 2000;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [4:0] cfg_wdata;
    logic in_valid;
    logic in_stall;
    logic [7:0] data_byte;
    logic end_of_stream;
    logic out_valid;
    logic out_stall;
    logic [7:0] out_byte;
    logic last_of_run;

    blz_pkg::blz_item_t pend_q[$];
    logic [7:0] exp_byte_q[$];
    logic exp_last_q[$];

    logic [15:0] trie[int];
    int unsigned next_idx;
    int unsigned cur_node;
    int unsigned par_node;
    logic ph_bit;
    logic ph_open;
    logic [7:0] pk_shift;
    int unsigned pk_count;
    logic [4:0] width_reg;
    int n_made;

    int idle_mode;
    int errors;

    binary_lz78_compressor_core u_dut (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_we(cfg_we),
        .cfg_wdata(cfg_wdata),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .data_byte(data_byte),
        .end_of_stream(end_of_stream),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .out_byte(out_byte),
        .last_of_run(last_of_run)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    function automatic int unsigned code_width();
        if (width_reg == 5'd0)
            return 1;
        if (width_reg > MAX_W)
            return MAX_W;
        return int'(width_reg);
    endfunction

    task automatic stream_clear();
        trie.delete();
        next_idx = 0;
        cur_node = 0;
        par_node = 0;
        ph_bit = 1'b0;
        ph_open = 1'b0;
        pk_shift = 8'h00;
        pk_count = 0;
    endtask

    task automatic expect_byte(input logic [7:0] v);
        exp_byte_q = {exp_byte_q, v};
        exp_last_q = {exp_last_q, 1'b0};
        n_made++;
    endtask

    task automatic pack_bit(input logic b);
        pk_shift = {pk_shift[6:0], b};
        pk_count++;
        if (pk_count == 8)
        begin
            expect_byte(pk_shift);
            pk_shift = 8'h00;
            pk_count = 0;
        end
    endtask

    task automatic pack_code(input int unsigned idx, input logic b);
        int unsigned w;
        w = code_width();
        for (int i = w; i > 0; i--)
            pack_bit(idx[i-1]);
        pack_bit(b);
    endtask

    task automatic walk_bit(input logic b);
        int slot;
        slot = ((cur_node & 16'hffff) << 1) | b;
        if (trie.exists(slot) && trie[slot] != 16'd0)
        begin
            par_node = cur_node;
            cur_node = trie[slot];
            ph_bit = b;
            ph_open = 1'b1;
            return;
        end
        if (next_idx < (32'd1 << code_width()) - 1)
        begin
            next_idx++;
            trie[slot] = next_idx[15:0];
        end
        pack_code(cur_node, b);
        cur_node = 0;
        par_node = 0;
        ph_bit = 1'b0;
        ph_open = 1'b0;
    endtask

    task automatic predict_codes(input logic [7:0] d, input logic eos);
        logic [7:0] pad;
        n_made = 0;
        for (int j = 7; j >= 0; j--)
            walk_bit(d[j]);
        if (eos)
        begin
            if (ph_open)
                pack_code(par_node, ph_bit);
            if (pk_count != 0)
            begin
                pad = pk_shift << (8 - pk_count);
                expect_byte(pad);
            end
            stream_clear();
        end
        if (n_made > 0)
            exp_last_q[$] = 1'b1;
    endtask

    function automatic logic idle_roll(input int pct);
        return $urandom_range(99) < pct;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            data_byte <= 8'h00;
            end_of_stream <= 1'b0;
        end
        else
        begin
            if (in_valid && !in_stall)
                predict_codes(data_byte, end_of_stream);
            if (!in_valid || !in_stall)
            begin
                if (pend_q.size() > 0 &&
                    !idle_roll((idle_mode == 1) ? 83 : (idle_mode == 3) ? 18 : 0))
                begin
                    blz_pkg::blz_item_t it;
                    it = pend_q.pop_front();
                    in_valid <= 1'b1;
                    data_byte <= it.data;
                    end_of_stream <= it.eos;
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_stall <= 1'b0;
        else
            out_stall <= idle_roll((idle_mode == 2) ? 83 : (idle_mode == 3) ? 18 : 0);
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (exp_byte_q.size() == 0)
            begin
                $error("unexpected out_byte actual %h", out_byte);
                errors++;
            end
            else
            begin
                logic [7:0] eb;
                logic el;
                eb = exp_byte_q.pop_front();
                el = exp_last_q.pop_front();
                if (out_byte !== eb)
                begin
                    $error("out_byte expected %h actual %h", eb, out_byte);
                    errors++;
                end
                if (last_of_run !== el)
                begin
                    $error("last_of_run expected %b actual %b", el, last_of_run);
                    errors++;
                end
            end
        end
    end

    task automatic add_item(input logic [7:0] d, input logic eos);
        blz_pkg::blz_item_t it;
        it.data = d;
        it.eos = eos;
        pend_q = {pend_q, it};
    endtask

    function automatic logic [7:0] pick_byte();
        logic [7:0] pool[6];
        pool = '{8'h00, 8'hff, 8'h0f, 8'hf0, 8'haa, 8'h55};
        if ($urandom_range(1))
            return pool[$urandom_range(5)];
        return 8'($urandom_range(255));
    endfunction

    task automatic drain();
        wait (pend_q.size() == 0);
        @(posedge clk);
        while (in_valid || exp_byte_q.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_width(input logic [4:0] v);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we <= 1'b0;
        width_reg = v;
    endtask

    initial
    begin
        logic [4:0] widths[6];
        logic [7:0] directed[20];
        widths = '{5'd9, 5'd1, 5'd16, 5'd0, 5'd31, 5'd5};
        directed = '{8'h00, 8'hff, 8'h00, 8'hff, 8'h55, 8'haa, 8'h80, 8'h01, 8'h00,
                     8'h00, 8'hff, 8'hff, 8'h7f, 8'hfe, 8'h0f, 8'hf0, 8'h00, 8'h00,
                     8'hc3, 8'h3c};
        errors = 0;
        idle_mode = 0;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_wdata = 5'd0;
        width_reg = blz_pkg::CFG_RESET;
        stream_clear();
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        repeat (CLEAR_CYCLES) @(posedge clk);
        for (int p = 0; p < 6; p++)
        begin
            write_width(widths[p]);
            idle_mode = p % 4;
            if (p == 0)
                foreach (directed[i])
                    add_item(directed[i], 1'b0);
            for (int i = 0; i < ((p == 0) ? 50 : 67); i++)
                add_item(pick_byte(), 1'b0);
            add_item(pick_byte(), 1'b1);
            drain();
            if (p < 5)
                repeat (CLEAR_CYCLES) @(posedge clk);
        end
        repeat (300) @(posedge clk);
        if (errors == 0 && exp_byte_q.size() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial
    begin
        #40000000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end
endmodule

FILE: filelist.f
+incdir+rtl/core
rtl/core/blz_pkg.sv
rtl/core/blz_front.sv
rtl/core/blz_back.sv
rtl/core/binary_lz78_compressor_core.sv
bench/tb.sv
